// File: src/kcl_pkg.sv
`timescale 1ns / 1ps

package kcl_pkg;

  localparam int CodeLenDef = 4;
  localparam int KeyW       = 4;
  localparam int TickW      = 12;
  localparam int WrongW     = 3;
  localparam int CfgIdxW    = 3;
  localparam int CfgDataW   = 16;

  localparam logic [TickW-1:0]  TickMax  = '1;
  localparam logic [WrongW-1:0] WrongMax = '1;

  localparam logic [KeyW-1:0] KEY_DIGIT_MAX = 4'd9;
  localparam logic [KeyW-1:0] KEY_STAR      = 4'd10;
  localparam logic [KeyW-1:0] KEY_HASH      = 4'd11;

  localparam logic [CfgIdxW-1:0] CFG_PASSCODE       = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_FAIL_LIMIT     = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_TYPING_TIMEOUT = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_UNLOCK_TIMEOUT = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_REMINDER_AFTER = 3'd4;

  localparam logic [15:0]       PasscodeRst  = 16'h1234;
  localparam logic [WrongW-1:0] FailLimitRst = 3'd3;
  localparam logic [TickW-1:0]  TypingToRst  = 12'd500;
  localparam logic [TickW-1:0]  UnlockToRst  = 12'd1500;
  localparam logic [TickW-1:0]  RemindRst    = 12'd1200;

  localparam logic [1:0] MCODE_IDLE     = 2'd0;
  localparam logic [1:0] MCODE_TYPING   = 2'd1;
  localparam logic [1:0] MCODE_UNLOCKED = 2'd2;
  localparam logic [1:0] MCODE_ALARM    = 2'd3;

  typedef enum logic [3:0] {
    MODE_IDLE     = 4'b0001,
    MODE_TYPING   = 4'b0010,
    MODE_UNLOCKED = 4'b0100,
    MODE_ALARM    = 4'b1000
  } mode_e;

  typedef enum logic [3:0] {
    ACT_NONE   = 4'd0,
    ACT_KEY    = 4'd1,
    ACT_DEL    = 4'd2,
    ACT_OK     = 4'd3,
    ACT_ERR    = 4'd4,
    ACT_READY  = 4'd5,
    ACT_REMIND = 4'd6,
    ACT_ALARM  = 4'd7,
    ACT_OPEN   = 4'd8,
    ACT_CLOSE  = 4'd9
  } action_e;

  typedef struct packed {
    logic [15:0]       passcode;
    logic [WrongW-1:0] fail_limit;
    logic [TickW-1:0]  typing_to;
    logic [TickW-1:0]  unlock_to;
    logic [TickW-1:0]  remind_after;
  } cfg_t;

  typedef struct packed {
    action_e act;
    logic    green;
    logic    red;
  } res_t;

  // All results of one tick, the number of them (1 to 3) and the mode code.
  typedef struct packed {
    res_t [2:0] res;
    logic [1:0] num;
    logic [1:0] mode;
  } step_t;

  function automatic logic [1:0] mode_code(mode_e m);
    logic [1:0] c;
    unique case (m)
      MODE_IDLE:     c = MCODE_IDLE;
      MODE_TYPING:   c = MCODE_TYPING;
      MODE_UNLOCKED: c = MCODE_UNLOCKED;
      MODE_ALARM:    c = MCODE_ALARM;
      default:       c = MCODE_IDLE;
    endcase
    return c;
  endfunction

endpackage

// File: src/kcl_ctrl.sv
`timescale 1ns / 1ps

module kcl_ctrl import kcl_pkg::*; #(
  parameter int CODE_LEN = CodeLenDef
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            fire_i,
  input  logic            key_down_i,
  input  logic [KeyW-1:0] key_code_i,
  input  logic            override_i,
  input  cfg_t            cfg_i,
  output step_t           step_o
);

  localparam int CntW = $clog2(CODE_LEN + 1);
  localparam logic [CntW-1:0] CntFull = CntW'(CODE_LEN);

  mode_e                        mode_q, mode_d;
  logic [CntW-1:0]              cnt_q, cnt_d;
  logic [CODE_LEN-1:0][KeyW-1:0] store_q, store_d;
  logic [WrongW-1:0]            wrong_q, wrong_d;
  logic [TickW-1:0]             ticks_q, ticks_d;
  logic                         rem_q, rem_d;
  logic                         key_was_q;
  logic                         green_q, green_d;

  logic                         pressed;
  logic                         is_digit;
  logic [TickW-1:0]             ticks_inc;
  logic [WrongW-1:0]            wrong_inc;
  logic [4*CODE_LEN+15:0]       pc_ext;
  logic                         match;
  res_t [2:0]                   res;
  logic [1:0]                   n;

  assign pressed   = key_down_i && !key_was_q;
  assign is_digit  = (key_code_i <= KEY_DIGIT_MAX);
  assign ticks_inc = (ticks_q == TickMax) ? ticks_q : ticks_q + 1'b1;
  assign wrong_inc = (wrong_q == WrongMax) ? wrong_q : wrong_q + 1'b1;
  // Passcode nibbles above bit 15 read as zero.
  assign pc_ext    = {(4*CODE_LEN)'(0), cfg_i.passcode};

  always_comb begin
    match = (cnt_q == CntFull);
    for (int i = 0; i < CODE_LEN; i++) begin
      if (store_q[i] != pc_ext[4*(CODE_LEN-1-i) +: 4]) begin
        match = 1'b0;
      end
    end
  end

  always_comb begin
    mode_d  = mode_q;
    cnt_d   = cnt_q;
    store_d = store_q;
    wrong_d = wrong_q;
    ticks_d = ticks_q;
    rem_d   = rem_q;
    green_d = green_q;
    res     = '{default: '{act: ACT_NONE, green: 1'b0, red: 1'b0}};
    n       = 2'd0;

    if (override_i) begin
      mode_d  = MODE_UNLOCKED;
      wrong_d = '0;
      ticks_d = '0;
      rem_d   = 1'b0;
      green_d = 1'b1;
      res[0]  = '{act: ACT_OK,   green: 1'b1, red: 1'b0};
      res[1]  = '{act: ACT_OPEN, green: 1'b1, red: 1'b0};
      n       = 2'd2;
    end else begin
      unique case (mode_q)
        MODE_IDLE: begin
          if (pressed && is_digit) begin
            mode_d  = MODE_TYPING;
            ticks_d = '0;
            for (int i = 0; i < CODE_LEN; i++) begin
              if (CntW'(i) == cnt_q) store_d[i] = key_code_i;
            end
            if (cnt_q < CntFull) cnt_d = cnt_q + 1'b1;
            res[0] = '{act: ACT_KEY, green: green_q, red: 1'b0};
            n      = 2'd1;
          end
        end
        MODE_TYPING: begin
          if (ticks_inc >= cfg_i.typing_to) begin
            ticks_d = ticks_inc;
            mode_d  = MODE_IDLE;
            cnt_d   = '0;
            store_d = '0;
            green_d = 1'b0;
            rem_d   = 1'b0;
            res[0]  = '{act: ACT_ERR,   green: green_q, red: 1'b0};
            res[1]  = '{act: ACT_CLOSE, green: 1'b0,    red: 1'b0};
            n       = 2'd2;
          end else if (pressed) begin
            ticks_d = '0;
            if (is_digit) begin
              if (cnt_q < CntFull) begin
                for (int i = 0; i < CODE_LEN; i++) begin
                  if (CntW'(i) == cnt_q) store_d[i] = key_code_i;
                end
                cnt_d  = cnt_q + 1'b1;
                res[0] = '{act: ACT_KEY, green: green_q, red: 1'b0};
              end else begin
                res[0] = '{act: ACT_ERR, green: green_q, red: 1'b1};
              end
              n = 2'd1;
            end else if (key_code_i == KEY_STAR) begin
              if (cnt_q != '0) begin
                cnt_d = cnt_q - 1'b1;
                for (int i = 0; i < CODE_LEN; i++) begin
                  if (CntW'(i) == cnt_d) store_d[i] = '0;
                end
                res[0] = '{act: ACT_DEL, green: green_q, red: 1'b0};
                n      = 2'd1;
              end
              // Deleting the only digit, or an empty store, abandons the entry.
              if (cnt_q <= CntW'(1)) begin
                mode_d   = MODE_IDLE;
                cnt_d    = '0;
                store_d  = '0;
                green_d  = 1'b0;
                rem_d    = 1'b0;
                res[n]   = '{act: ACT_CLOSE, green: 1'b0, red: 1'b0};
                res[n+1] = '{act: ACT_ERR,   green: 1'b0, red: 1'b0};
                n        = n + 2'd2;
              end
            end else if (key_code_i == KEY_HASH) begin
              if (match) begin
                mode_d  = MODE_UNLOCKED;
                wrong_d = '0;
                rem_d   = 1'b0;
                green_d = 1'b1;
                res[0]  = '{act: ACT_OK,   green: 1'b1, red: 1'b0};
                res[1]  = '{act: ACT_OPEN, green: 1'b1, red: 1'b0};
                n       = 2'd2;
              end else begin
                wrong_d = wrong_inc;
                res[0]  = '{act: ACT_ERR, green: green_q, red: 1'b1};
                n       = 2'd1;
                if (wrong_inc >= cfg_i.fail_limit) begin
                  mode_d = MODE_ALARM;
                end else begin
                  mode_d  = MODE_IDLE;
                  cnt_d   = '0;
                  store_d = '0;
                  green_d = 1'b0;
                  rem_d   = 1'b0;
                  res[1]  = '{act: ACT_CLOSE, green: 1'b0, red: 1'b0};
                  n       = 2'd2;
                end
              end
            end
          end else begin
            ticks_d = ticks_inc;
          end
        end
        MODE_UNLOCKED: begin
          ticks_d = ticks_inc;
          if (ticks_inc >= cfg_i.unlock_to) begin
            mode_d  = MODE_IDLE;
            cnt_d   = '0;
            store_d = '0;
            green_d = 1'b0;
            rem_d   = 1'b0;
            res[0]  = '{act: ACT_CLOSE, green: 1'b0, red: 1'b0};
            res[1]  = '{act: ACT_READY, green: 1'b0, red: 1'b0};
            n       = 2'd2;
          end else begin
            if (ticks_inc >= cfg_i.remind_after && !rem_q) begin
              res[0] = '{act: ACT_REMIND, green: green_q, red: 1'b0};
              rem_d  = 1'b1;
              n      = 2'd1;
            end
            if (pressed && key_code_i == KEY_HASH) begin
              ticks_d = '0;
            end else if (pressed && key_code_i == KEY_STAR) begin
              mode_d  = MODE_IDLE;
              cnt_d   = '0;
              store_d = '0;
              green_d = 1'b0;
              rem_d   = 1'b0;
              res[n]  = '{act: ACT_CLOSE, green: 1'b0, red: 1'b0};
              n       = n + 2'd1;
            end
          end
        end
        MODE_ALARM: begin
          wrong_d = '0;
          mode_d  = MODE_IDLE;
          cnt_d   = '0;
          store_d = '0;
          green_d = 1'b0;
          rem_d   = 1'b0;
          res[0]  = '{act: ACT_ALARM, green: green_q, red: 1'b1};
          res[1]  = '{act: ACT_CLOSE, green: 1'b0,    red: 1'b0};
          n       = 2'd2;
        end
        default: begin
          mode_d = MODE_IDLE;
        end
      endcase
    end

    // A tick with no event still reports once.
    if (n == 2'd0) begin
      res[0] = '{act: ACT_NONE, green: green_d, red: 1'b0};
      n      = 2'd1;
    end
  end

  assign step_o.res  = res;
  assign step_o.num  = n;
  assign step_o.mode = mode_code(mode_d);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= MODE_IDLE;
      cnt_q     <= '0;
      store_q   <= '0;
      wrong_q   <= '0;
      ticks_q   <= '0;
      rem_q     <= 1'b0;
      key_was_q <= 1'b0;
      green_q   <= 1'b0;
    end else if (fire_i) begin
      mode_q    <= mode_d;
      cnt_q     <= cnt_d;
      store_q   <= store_d;
      wrong_q   <= wrong_d;
      ticks_q   <= ticks_d;
      rem_q     <= rem_d;
      key_was_q <= key_down_i;
      green_q   <= green_d;
    end
  end

endmodule

// File: src/kcl_rbuf.sv
`timescale 1ns / 1ps

module kcl_rbuf import kcl_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       load_i,
  input  step_t      step_i,
  output logic       free_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [3:0] action_o,
  output logic       open_led_o,
  output logic       red_led_o,
  output logic [1:0] mode_o,
  output logic       last_o
);

  step_t      buf_q;
  logic       valid_q;
  logic [1:0] idx_q;
  res_t       cur;
  logic       take;

  always_comb begin
    case (idx_q)
      2'd1:    cur = buf_q.res[1];
      2'd2:    cur = buf_q.res[2];
      default: cur = buf_q.res[0];
    endcase
  end

  assign last_o      = (idx_q == buf_q.num - 2'd1);
  assign take        = valid_q && out_ready_i;
  // The next tick may load in the same cycle as the final transfer.
  assign free_o      = !valid_q || (take && last_o);
  assign out_valid_o = valid_q;
  assign action_o    = cur.act;
  assign open_led_o  = cur.green;
  assign red_led_o   = cur.red;
  assign mode_o      = buf_q.mode;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= '0;
    end else if (load_i) begin
      valid_q <= 1'b1;
      idx_q   <= '0;
    end else if (take) begin
      if (last_o) valid_q <= 1'b0;
      idx_q <= idx_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) buf_q <= step_i;
  end

endmodule

// File: src/keypad_code_lock.sv
`timescale 1ns / 1ps

// Keypad door lock, one input transfer per polling tick.
// Input channel (in_valid_i/in_ready_o): key_down_i, key_code_i and override_i
// of one tick. Output channel (out_valid_o/out_ready_i): one to three results per
// tick, each with action, LED levels and the mode after the tick; last_o marks
// the final result of a tick.
// A tick is first captured in an input register, then decoded and stored into
// the lock state and a result buffer. The first result is offered by the result
// buffer once its tick has passed the input register and been loaded into it;
// while out_ready_i is high, the results of a tick follow one per cycle.
// Throughput is one tick per cycle when each tick gives a single result and the
// receiver is ready; a tick with more results holds the result buffer until its
// last result transfers; the pace is set by the results per tick, at most three.
// When the receiver stalls, the buffer holds its results and the input register
// holds one more tick; in_ready_o falls once both are occupied.
// Configuration (cfg_we_i, cfg_idx_i, cfg_data_i) must be written only while no
// tick is in flight; the block does not check it. Reset empties both registers,
// sets mode idle with no digits and loads the default passcode and timeouts.

module keypad_code_lock import kcl_pkg::*; #(
  parameter int CODE_LEN = CodeLenDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic                key_down_i,
  input  logic [KeyW-1:0]     key_code_i,
  input  logic                override_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [3:0]          action_o,
  output logic                open_led_o,
  output logic                red_led_o,
  output logic [1:0]          mode_o,
  output logic                last_o
);

  cfg_t            cfg_q;
  logic            s1_valid_q;
  logic            s1_down_q;
  logic [KeyW-1:0] s1_code_q;
  logic            s1_ovr_q;
  logic            rb_free;
  logic            fire;
  step_t           step;

  assign fire       = s1_valid_q && rb_free;
  assign in_ready_o = !s1_valid_q || fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.passcode     <= PasscodeRst;
      cfg_q.fail_limit   <= FailLimitRst;
      cfg_q.typing_to    <= TypingToRst;
      cfg_q.unlock_to    <= UnlockToRst;
      cfg_q.remind_after <= RemindRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_PASSCODE:       cfg_q.passcode     <= cfg_data_i;
        CFG_FAIL_LIMIT:     cfg_q.fail_limit   <= cfg_data_i[WrongW-1:0];
        CFG_TYPING_TIMEOUT: cfg_q.typing_to    <= cfg_data_i[TickW-1:0];
        CFG_UNLOCK_TIMEOUT: cfg_q.unlock_to    <= cfg_data_i[TickW-1:0];
        CFG_REMINDER_AFTER: cfg_q.remind_after <= cfg_data_i[TickW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      s1_down_q <= key_down_i;
      s1_code_q <= key_code_i;
      s1_ovr_q  <= override_i;
    end
  end

  kcl_ctrl #(
    .CODE_LEN (CODE_LEN)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .fire_i     (fire),
    .key_down_i (s1_down_q),
    .key_code_i (s1_code_q),
    .override_i (s1_ovr_q),
    .cfg_i      (cfg_q),
    .step_o     (step)
  );

  kcl_rbuf u_rbuf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (fire),
    .step_i      (step),
    .free_o      (rb_free),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .action_o    (action_o),
    .open_led_o  (open_led_o),
    .red_led_o   (red_led_o),
    .mode_o      (mode_o),
    .last_o      (last_o)
  );

endmodule
